FILE: src/beg_pkg.sv
package beg_pkg;

   // Register indexes on the configuration port.
   localparam logic CSR_POINT_COUNT = 1'b0;
   localparam logic CSR_WAVE_LENGTH = 1'b1;

   localparam int LEVEL_BITS = 10;
   localparam int SLOT_BITS  = 4;
   localparam int COUNT_BITS = 5;
   localparam int CHAN_BITS  = 3;
   localparam int WAVE_BITS  = 24;
   localparam int GAIN_BITS  = 16;
   localparam int GAIN_DEPTH = 1024;
   localparam logic [LEVEL_BITS-1:0] UNITY_LEVEL = 10'd200;

   // Classification that the front end attaches to every queued item.
   typedef struct packed {
      logic is_write;
      logic write_ok;
      logic scan;
   } item_class_type;

   typedef logic signed [GAIN_BITS-1:0] gain_type;
   typedef gain_type gain_table_type [GAIN_DEPTH];

   // Gain in Q3.12: round(4096 * (1 + 6 * ln((800 + L) / 1000))).
   function automatic gain_table_type build_gain_table();
      gain_table_type tbl;
      real x;
      for (int l = 0; l < GAIN_DEPTH; l++) begin
         x = 4096.0 * (1.0 + 6.0 * $ln((800.0 + l) / 1000.0));
         if (x >= 0.0) begin
            tbl[l] = GAIN_BITS'($rtoi(x + 0.5));
         end else begin
            tbl[l] = GAIN_BITS'(-$rtoi(-x + 0.5));
         end
      end
      return tbl;
   endfunction

   localparam gain_table_type GAIN_TABLE = build_gain_table();

   // Number of breakpoints actually in use.
   function automatic logic [COUNT_BITS-1:0] eff_count(logic [COUNT_BITS-1:0] pc, int maxp);
      logic [COUNT_BITS-1:0] r;
      if (32'(pc) > maxp) begin
         r = COUNT_BITS'(maxp);
      end else begin
         r = pc;
      end
      return r;
   endfunction

endpackage

FILE: src/breakpoint_envelope_gain_unit.sv
// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  tuser: kind; tdata: breakpoint write or sample
// rsp      out        rsp_tvalid/rsp_tready  tdata: scaled sample, level, hit, channel
// csr      in         csr_valid/csr_ready    csr_index selects the register, csr_data the value
//
// A breakpoint write is done by the back end as it takes the item from the queue. A
// sample is matched by a table scan through the single read port of the breakpoint
// memory, then goes through the bit-serial divider and on to gain lookup, scaling and
// output; a miss skips the divide.
// Reset clears the control state; the breakpoint table is undefined until written.
// A two-entry queue lets input transfers continue while the back end waits on rsp_tready.
module breakpoint_envelope_gain_unit import beg_pkg::*; #(
   parameter int MAX_POINTS    = 16,
   parameter int POSITION_BITS = 24,
   parameter int SAMPLE_BITS   = 24,
   localparam int REQ_RAW = SLOT_BITS + 2 * POSITION_BITS + LEVEL_BITS + SAMPLE_BITS + CHAN_BITS,
   localparam int REQ_W   = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW = SAMPLE_BITS + LEVEL_BITS + 1 + CHAN_BITS,
   localparam int RSP_W   = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // From bit 0: point_slot, point_position, point_level, sample_value,
   // frame_position, channel, zero fill.
   input  logic [REQ_W-1:0]     req_tdata,
   // Bit 0: kind.
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // From bit 0: scaled_sample, envelope_level, segment_hit, out_channel, zero fill.
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [WAVE_BITS-1:0] csr_data
);

   localparam int QW = 3 + REQ_RAW;

   localparam int O_SLOT = 0;
   localparam int O_PPOS = O_SLOT + SLOT_BITS;
   localparam int O_PLVL = O_PPOS + POSITION_BITS;
   localparam int O_SMP  = O_PLVL + LEVEL_BITS;
   localparam int O_FRM  = O_SMP + SAMPLE_BITS;
   localparam int O_CHAN = O_FRM + POSITION_BITS;

   // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
   logic [COUNT_BITS-1:0] point_count_ff, point_count_in;
   logic [WAVE_BITS-1:0]  wave_length_ff, wave_length_in;

   assign csr_ready = 1'b1;

   always_comb begin
      point_count_in = point_count_ff;
      wave_length_in = wave_length_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POINT_COUNT: point_count_in = csr_data[COUNT_BITS-1:0];
            CSR_WAVE_LENGTH: wave_length_in = csr_data;
            default: begin
               point_count_in = point_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= COUNT_BITS'(2);
         wave_length_ff <= '0;
      end else begin
         point_count_ff <= point_count_in;
         wave_length_ff <= wave_length_in;
      end
   end

   logic          push;
   logic [QW-1:0] push_data;
   logic          q_full;
   logic          q_empty;
   logic          pop;
   logic [QW-1:0] pop_data;

   // The front end classifies each transfer as a table write or a sample and
   // decides up front whether the sample needs a segment search at all.
   beg_front #(
      .MAX_POINTS    (MAX_POINTS),
      .POSITION_BITS (POSITION_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_front (
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .kind           (req_tuser),
      .point_slot     (req_tdata[O_SLOT +: SLOT_BITS]),
      .point_position (req_tdata[O_PPOS +: POSITION_BITS]),
      .point_level    (req_tdata[O_PLVL +: LEVEL_BITS]),
      .sample_value   (req_tdata[O_SMP +: SAMPLE_BITS]),
      .frame_position (req_tdata[O_FRM +: POSITION_BITS]),
      .channel        (req_tdata[O_CHAN +: CHAN_BITS]),
      .point_count    (point_count_ff),
      .wave_length    (wave_length_ff),
      .queue_full     (q_full),
      .push           (push),
      .push_data      (push_data)
   );

   beg_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   logic signed [SAMPLE_BITS-1:0] scaled_sample;
   logic [LEVEL_BITS-1:0]         envelope_level;
   logic                          segment_hit;
   logic [CHAN_BITS-1:0]          out_channel;

   // The back end owns the breakpoint memory, searches for the segment, runs the
   // interpolation divide and applies the gain, then holds the result for rsp.
   beg_back #(
      .MAX_POINTS    (MAX_POINTS),
      .POSITION_BITS (POSITION_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .point_count    (point_count_ff),
      .queue_empty    (q_empty),
      .queue_data     (pop_data),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .scaled_sample  (scaled_sample),
      .envelope_level (envelope_level),
      .segment_hit    (segment_hit),
      .out_channel    (out_channel)
   );

   assign rsp_tdata = RSP_W'({out_channel, segment_hit, envelope_level, scaled_sample});

endmodule

FILE: src/beg_ram.sv
module beg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/beg_queue.sv
module beg_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   // Two entries, so the front end can keep taking items while the back end works.
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: src/beg_front.sv
module beg_front import beg_pkg::*; #(
   parameter int MAX_POINTS    = 16,
   parameter int POSITION_BITS = 24,
   parameter int SAMPLE_BITS   = 24,
   localparam int QW = 3 + SLOT_BITS + 2 * POSITION_BITS + LEVEL_BITS + SAMPLE_BITS + CHAN_BITS
) (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     kind,
   input  logic [SLOT_BITS-1:0]     point_slot,
   input  logic [POSITION_BITS-1:0] point_position,
   input  logic [LEVEL_BITS-1:0]    point_level,
   input  logic [SAMPLE_BITS-1:0]   sample_value,
   input  logic [POSITION_BITS-1:0] frame_position,
   input  logic [CHAN_BITS-1:0]     channel,
   input  logic [COUNT_BITS-1:0]    point_count,
   input  logic [WAVE_BITS-1:0]     wave_length,
   input  logic                     queue_full,
   output logic                     push,
   output logic [QW-1:0]            push_data
);

   item_class_type cls;

   always_comb begin
      cls.is_write = kind;
      cls.write_ok = kind && (32'(point_slot) < MAX_POINTS);
      cls.scan     = !kind && (32'(frame_position) <= 32'(wave_length))
                     && (eff_count(point_count, MAX_POINTS) >= COUNT_BITS'(2));
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;
   assign push_data  = {cls, point_slot, point_position, point_level,
                        sample_value, frame_position, channel};

endmodule

FILE: src/beg_back.sv
module beg_back import beg_pkg::*; #(
   parameter int MAX_POINTS    = 16,
   parameter int POSITION_BITS = 24,
   parameter int SAMPLE_BITS   = 24,
   localparam int QW = 3 + SLOT_BITS + 2 * POSITION_BITS + LEVEL_BITS + SAMPLE_BITS + CHAN_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [COUNT_BITS-1:0]         point_count,
   input  logic                          queue_empty,
   input  logic [QW-1:0]                 queue_data,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic signed [SAMPLE_BITS-1:0] scaled_sample,
   output logic [LEVEL_BITS-1:0]         envelope_level,
   output logic                          segment_hit,
   output logic [CHAN_BITS-1:0]          out_channel
);

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int EW  = POSITION_BITS + LEVEL_BITS;
   localparam int NW  = POSITION_BITS + LEVEL_BITS;
   localparam int CW  = $clog2(NW);
   localparam int PW  = SAMPLE_BITS + GAIN_BITS;
   localparam int SW  = PW + 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LOAD  = 4'd1;
   localparam logic [3:0] ST_CHECK = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_LEVEL = 4'd5;
   localparam logic [3:0] ST_GAIN  = 4'd6;
   localparam logic [3:0] ST_SCALE = 4'd7;
   localparam logic [3:0] ST_SAT   = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   item_class_type               q_cls;
   logic [SLOT_BITS-1:0]         q_slot;
   logic [POSITION_BITS-1:0]     q_ppos;
   logic [LEVEL_BITS-1:0]        q_plvl;
   logic [SAMPLE_BITS-1:0]       q_smp;
   logic [POSITION_BITS-1:0]     q_frm;
   logic [CHAN_BITS-1:0]         q_chan;

   assign {q_cls, q_slot, q_ppos, q_plvl, q_smp, q_frm, q_chan} = queue_data;

   logic [3:0]                   state_ff, state_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic signed [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic [POSITION_BITS-1:0]     pos_ff, pos_in;
   logic [CHAN_BITS-1:0]         chan_ff, chan_in;
   logic [POSITION_BITS-1:0]     prev_pos_ff, prev_pos_in;
   logic [LEVEL_BITS-1:0]        prev_lvl_ff, prev_lvl_in;
   logic [POSITION_BITS-1:0]     x0_ff, x0_in;
   logic [POSITION_BITS-1:0]     den_ff, den_in;
   logic [LEVEL_BITS-1:0]        y0_ff, y0_in;
   logic [LEVEL_BITS-1:0]        dy_ff, dy_in;
   logic                         neg_ff, neg_in;
   logic [NW-1:0]                nq_ff, nq_in;
   logic [POSITION_BITS-1:0]     rem_ff, rem_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [LEVEL_BITS-1:0]        lvl_ff, lvl_in;
   logic                         hit_ff, hit_in;
   gain_type                     gain_ff, gain_in;
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] res_ff, res_in;
   logic                         ov_ff, ov_in;
   logic signed [SAMPLE_BITS-1:0] o_smp_ff, o_smp_in;
   logic [LEVEL_BITS-1:0]        o_lvl_ff, o_lvl_in;
   logic                         o_hit_ff, o_hit_in;
   logic [CHAN_BITS-1:0]         o_chan_ff, o_chan_in;

   logic                         we;
   logic [AW-1:0]                waddr;
   logic [EW-1:0]                rdata;
   logic [POSITION_BITS-1:0]     r_pos;
   logic [LEVEL_BITS-1:0]        r_lvl;
   logic [COUNT_BITS-1:0]        eff;
   logic [POSITION_BITS:0]       trial;
   logic                         qbit;
   logic signed [SW-1:0]         rsum;
   logic signed [SW-1:0]         rsh;
   logic                         load;

   assign {r_pos, r_lvl} = rdata;
   assign eff   = eff_count(point_count, MAX_POINTS);
   assign waddr = AW'(32'(q_slot));

   beg_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata ({q_ppos, q_plvl}),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   // One restoring division step per cycle.
   always_comb begin
      trial = {rem_ff, nq_ff[NW-1]};
      qbit  = (trial >= {1'b0, den_ff});
   end

   // Rounding of the scaled sample; ST_SAT then saturates it.
   always_comb begin
      rsum = $signed({prod_ff[PW-1], prod_ff}) + SW'(2048);
      rsh  = rsum >>> 12;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      smp_in      = smp_ff;
      pos_in      = pos_ff;
      chan_in     = chan_ff;
      prev_pos_in = prev_pos_ff;
      prev_lvl_in = prev_lvl_ff;
      x0_in       = x0_ff;
      den_in      = den_ff;
      y0_in       = y0_ff;
      dy_in       = dy_ff;
      neg_in      = neg_ff;
      nq_in       = nq_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      lvl_in      = lvl_ff;
      hit_in      = hit_ff;
      gain_in     = gain_ff;
      prod_in     = prod_ff;
      res_in      = res_ff;
      ov_in       = ov_ff;
      pop         = 1'b0;
      we          = 1'b0;
      load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (q_cls.is_write) begin
                  we = q_cls.write_ok;
               end else begin
                  smp_in  = $signed(q_smp);
                  pos_in  = q_frm;
                  chan_in = q_chan;
                  idx_in  = '0;
                  if (q_cls.scan) begin
                     state_in = ST_LOAD;
                  end else begin
                     lvl_in   = UNITY_LEVEL;
                     hit_in   = 1'b0;
                     res_in   = $signed(q_smp);
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            prev_pos_in = r_pos;
            prev_lvl_in = r_lvl;
            if (idx_ff == '0) begin
               idx_in   = AW'(1);
               state_in = ST_LOAD;
            end else if ((prev_pos_ff <= pos_ff) && (r_pos > pos_ff)) begin
               x0_in    = prev_pos_ff;
               den_in   = r_pos - prev_pos_ff;
               y0_in    = prev_lvl_ff;
               neg_in   = (r_lvl < prev_lvl_ff);
               dy_in    = (r_lvl < prev_lvl_ff) ? (prev_lvl_ff - r_lvl) : (r_lvl - prev_lvl_ff);
               state_in = ST_MUL;
            end else if (32'(idx_ff) + 32'd1 >= 32'(eff)) begin
               lvl_in   = UNITY_LEVEL;
               hit_in   = 1'b0;
               res_in   = smp_ff;
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_LOAD;
            end
         end
         ST_MUL: begin
            nq_in    = NW'(dy_ff) * NW'(pos_ff - x0_ff);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? POSITION_BITS'(trial - {1'b0, den_ff}) : trial[POSITION_BITS-1:0];
            nq_in  = {nq_ff[NW-2:0], qbit};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW - 1)) begin
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            // Floor of a negative ratio rounds away from zero when a remainder is left.
            if (neg_ff) begin
               lvl_in = y0_ff - nq_ff[LEVEL_BITS-1:0] - LEVEL_BITS'(rem_ff != '0);
            end else begin
               lvl_in = y0_ff + nq_ff[LEVEL_BITS-1:0];
            end
            hit_in   = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            gain_in  = GAIN_TABLE[lvl_ff];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = smp_ff * gain_ff;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            ov_in = !((rsh[SW-1:SAMPLE_BITS-1] == '0) || (rsh[SW-1:SAMPLE_BITS-1] == '1));
            if ((rsh[SW-1:SAMPLE_BITS-1] == '0) || (rsh[SW-1:SAMPLE_BITS-1] == '1)) begin
               res_in = rsh[SAMPLE_BITS-1:0];
            end else if (rsh[SW-1]) begin
               res_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end else begin
               res_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_tvalid || rsp_tready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
      o_smp_in     = load ? res_ff  : o_smp_ff;
      o_lvl_in     = load ? lvl_ff  : o_lvl_ff;
      o_hit_in     = load ? hit_ff  : o_hit_ff;
      o_chan_in    = load ? chan_ff : o_chan_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      smp_ff      <= smp_in;
      pos_ff      <= pos_in;
      chan_ff     <= chan_in;
      prev_pos_ff <= prev_pos_in;
      prev_lvl_ff <= prev_lvl_in;
      x0_ff       <= x0_in;
      den_ff      <= den_in;
      y0_ff       <= y0_in;
      dy_ff       <= dy_in;
      neg_ff      <= neg_in;
      nq_ff       <= nq_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      lvl_ff      <= lvl_in;
      hit_ff      <= hit_in;
      gain_ff     <= gain_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      ov_ff       <= ov_in;
      o_smp_ff    <= o_smp_in;
      o_lvl_ff    <= o_lvl_in;
      o_hit_ff    <= o_hit_in;
      o_chan_ff   <= o_chan_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign scaled_sample  = o_smp_ff;
   assign envelope_level = o_lvl_ff;
   assign segment_hit    = o_hit_ff && !(ov_ff && 1'b0);
   assign out_channel    = o_chan_ff;

endmodule
